// ===== src/race_timer_controller_unit_assert.svh =====
// assertion macros shared by the race timer controller rtl
`ifndef RACE_TIMER_CONTROLLER_UNIT_ASSERT_SVH
`define RACE_TIMER_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RTC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rtc assertion failed");

// next-cycle implication, checked outside reset
`define RTC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rtc assertion failed");

`endif

// ===== src/rtc_pkg.sv =====
// types, constants and codes of the race timer controller
`default_nettype none

package rtc_pkg;

    // sample and hold counter widths
    localparam int SAMPLE_BITS = 10;
    localparam int HOLD_BITS   = 16;

    // debounce counter, saturating
    localparam int STABLE_BITS = 9;

    // time base
    localparam int MS_BITS        = 7;
    localparam int MS_PER_TENTH   = 100;
    localparam int TENTH_CNT_BITS = 9;
    localparam int PROD_BITS      = SAMPLE_BITS + 8;

    // configuration
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_LONG_PRESS    = 2'd1,
        CFG_LIGHT_RISE    = 2'd2,
        CFG_DISPLAY_DELAY = 2'd3
    } cfg_index_t;

    localparam logic [7:0]  DEBOUNCE_RST      = 8'd50;
    localparam logic [15:0] LONG_PRESS_RST    = 16'd2000;
    localparam logic [6:0]  LIGHT_RISE_RST    = 7'd10;
    localparam logic [7:0]  DISPLAY_DELAY_RST = 8'd20;

    typedef enum logic [1:0] {
        LAMP_OFF   = 2'd0,
        LAMP_GREEN = 2'd1,
        LAMP_RED   = 2'd2
    } lamp_t;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_STARTED  = 3'd1,
        EV_FINISHED = 3'd2,
        EV_ABORTED  = 3'd3,
        EV_CLEAR    = 3'd4
    } event_t;

    typedef struct packed {
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
    } digits_t;

    localparam digits_t DIGITS_MAX = '{minutes: 7'd99, seconds: 6'd59, tenths: 4'd9};

    typedef struct packed {
        logic button_level;
        logic [SAMPLE_BITS-1:0] light_sample;
    } item_t;

    typedef struct packed {
        logic       race_running;
        logic [6:0] minutes;
        logic [5:0] seconds;
        logic [3:0] tenths;
        logic       show_time;
        logic [1:0] lamp;
        logic [2:0] event_res;
    } result_t;

    // control from the race logic to the time base
    typedef struct packed {
        logic commit;
        logic run;
        logic restart;
    } time_ctrl_t;

    // time after the committed tick
    typedef struct packed {
        digits_t digits;
        logic [TENTH_CNT_BITS-1:0] tenth_count;
    } time_stat_t;

endpackage

`default_nettype wire

// ===== src/rtc_time_base.sv =====
// millisecond time base with minute, second and tenth digits
`default_nettype none
`include "race_timer_controller_unit_assert.svh"

module rtc_time_base
    import rtc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire time_ctrl_t ctrl,
    output time_stat_t      stat_next
);

    logic [MS_BITS-1:0]        ms_reg;
    logic [MS_BITS-1:0]        ms_next;
    digits_t                   digits_reg;
    digits_t                   digits_next;
    logic [TENTH_CNT_BITS-1:0] count_reg;
    logic [TENTH_CNT_BITS-1:0] count_next;
    digits_t                   rolled;
    logic                      saturated;
    logic                      tenth_wrap;

    // one millisecond step, holding at the top value
    always_comb
    begin
        saturated  = (digits_reg == DIGITS_MAX);
        tenth_wrap = (ms_reg == MS_BITS'(MS_PER_TENTH - 1));
        rolled     = digits_reg;
        if (digits_reg.tenths == 4'd9)
        begin
            rolled.tenths = 4'd0;
            if (digits_reg.seconds == 6'd59)
            begin
                rolled.seconds = 6'd0;
                rolled.minutes = digits_reg.minutes + 7'd1;
            end
            else
            begin
                rolled.seconds = digits_reg.seconds + 6'd1;
            end
        end
        else
        begin
            rolled.tenths = digits_reg.tenths + 4'd1;
        end

        ms_next     = ms_reg;
        digits_next = digits_reg;
        count_next  = count_reg;
        if (ctrl.restart)
        begin
            ms_next     = '0;
            digits_next = '0;
            count_next  = '0;
        end
        else if (ctrl.run && !saturated)
        begin
            if (tenth_wrap)
            begin
                ms_next     = '0;
                digits_next = rolled;
                if (!(&count_reg))
                begin
                    count_next = count_reg + TENTH_CNT_BITS'(1);
                end
            end
            else
            begin
                ms_next = ms_reg + MS_BITS'(1);
            end
        end
    end

    assign stat_next.digits      = digits_next;
    assign stat_next.tenth_count = count_next;

    // time registers move on each committed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg     <= '0;
            digits_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctrl.commit)
        begin
            ms_reg     <= ms_next;
            digits_reg <= digits_next;
            count_reg  <= count_next;
        end
    end

    `RTC_ASSERT_NOW(a_digits_range, clk, rst_n, 1'b1,
        digits_reg.tenths <= 4'd9 && digits_reg.seconds <= 6'd59)
    `RTC_ASSERT_NEXT(a_hold_at_top, clk, rst_n,
        ctrl.commit && !ctrl.restart && saturated, digits_reg == DIGITS_MAX)
    `RTC_ASSERT_NEXT(a_restart_clears, clk, rst_n, ctrl.commit && ctrl.restart,
        ms_reg == '0 && digits_reg == '0 && count_reg == '0)

endmodule

`default_nettype wire

// ===== src/race_timer_controller_unit.sv =====
// top level of the race timer controller
`default_nettype none
`include "race_timer_controller_unit_assert.svh"

// Race timer controller: one item per millisecond tick carries the raw button
// level and a light sample, and each item gives exactly one result with the
// race flag, the elapsed time, the display flag, the lamp and an event code.
// An item passes an input register, is evaluated in one pass against the
// race state, and lands in the result register, from which its result is
// offered; one item is taken every cycle as long as results are taken;
// while a result waits, the input register can still take
// one item. Configuration writes (debounce, long press, light rise percent,
// display delay) take effect at once and belong where no transfer is in flight.
module race_timer_controller_unit
    import rtc_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                      item_valid,
    output logic                           item_ready,
    input  wire item_t                     item,
    output logic                           result_valid,
    input  wire logic                      result_ready,
    output result_t                        result
);

    // configuration registers
    logic [7:0]  debounce_reg;
    logic [15:0] long_press_reg;
    logic [6:0]  light_rise_reg;
    logic [7:0]  display_delay_reg;

    // pipeline registers
    logic    item_valid_reg;
    item_t   item_reg;
    logic    result_valid_reg;
    result_t result_reg;
    logic    advance;
    logic    commit;

    // race state
    logic                   last_level_reg;
    logic [STABLE_BITS-1:0] stable_reg;
    logic                   press_reg;
    logic                   long_seen_reg;
    logic [HOLD_BITS-1:0]   hold_reg;
    logic                   timing_reg;
    logic [SAMPLE_BITS-1:0] start_light_reg;
    lamp_t                  lamp_reg;

    logic [STABLE_BITS-1:0] stable_next;
    logic                   press_next;
    logic                   long_seen_next;
    logic [HOLD_BITS-1:0]   hold_next;
    logic                   timing_next;
    logic [SAMPLE_BITS-1:0] start_light_next;
    lamp_t                  lamp_next;
    event_t                 event_next;
    result_t                result_next;

    logic                   act;
    logic                   start;
    logic                   light_done;
    logic [SAMPLE_BITS-1:0] rise;
    logic [PROD_BITS-1:0]   rise_scaled;
    logic [PROD_BITS-1:0]   limit_scaled;
    time_ctrl_t             time_ctrl;
    time_stat_t             time_next;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RST;
            long_press_reg    <= LONG_PRESS_RST;
            light_rise_reg    <= LIGHT_RISE_RST;
            display_delay_reg <= DISPLAY_DELAY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_DEBOUNCE:      debounce_reg      <= cfg_data[7:0];
                CFG_LONG_PRESS:    long_press_reg    <= cfg_data[15:0];
                CFG_LIGHT_RISE:    light_rise_reg    <= cfg_data[6:0];
                CFG_DISPLAY_DELAY: display_delay_reg <= cfg_data[7:0];
                default:           debounce_reg      <= debounce_reg;
            endcase
        end
    end

    // handshake: the input register empties when the result register is free
    assign advance      = !result_valid_reg || result_ready;
    assign commit       = item_valid_reg && advance;
    assign item_ready   = !item_valid_reg || advance;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // light rise test against the latched start sample
    always_comb
    begin
        rise         = item_reg.light_sample - start_light_reg;
        rise_scaled  = PROD_BITS'(rise) * PROD_BITS'(100);
        limit_scaled = (PROD_BITS'(light_rise_reg) + PROD_BITS'(1))
                       * PROD_BITS'(start_light_reg);
        if (start_light_reg == '0)
        begin
            light_done = (item_reg.light_sample != '0);
        end
        else
        begin
            light_done = (item_reg.light_sample > start_light_reg)
                         && (rise_scaled >= limit_scaled);
        end
    end

    // debounce and button decisions for the tick in the input register
    always_comb
    begin
        if (item_reg.button_level != last_level_reg)
        begin
            stable_next = '0;
        end
        else if (!(&stable_reg))
        begin
            stable_next = stable_reg + STABLE_BITS'(1);
        end
        else
        begin
            stable_next = stable_reg;
        end
        act = (stable_next > STABLE_BITS'(debounce_reg));

        press_next       = press_reg;
        long_seen_next   = long_seen_reg;
        hold_next        = hold_reg;
        timing_next      = timing_reg;
        start_light_next = start_light_reg;
        lamp_next        = lamp_reg;
        event_next       = EV_NONE;
        start            = 1'b0;

        if (act)
        begin
            if (item_reg.button_level)
            begin
                if (!press_reg)
                begin
                    press_next     = 1'b1;
                    long_seen_next = 1'b0;
                    hold_next      = '0;
                end
                else
                begin
                    if (!(&hold_reg))
                    begin
                        hold_next = hold_reg + HOLD_BITS'(1);
                    end
                    if (!long_seen_reg && (32'(hold_next) > 32'(long_press_reg)))
                    begin
                        long_seen_next = 1'b1;
                        if (timing_reg)
                        begin
                            timing_next = 1'b0;
                            lamp_next   = LAMP_RED;
                            event_next  = EV_ABORTED;
                        end
                        else
                        begin
                            event_next = EV_CLEAR;
                        end
                    end
                end
            end
            else
            begin
                if (press_reg)
                begin
                    press_next = 1'b0;
                    if (!timing_reg && !long_seen_reg)
                    begin
                        start            = 1'b1;
                        timing_next      = 1'b1;
                        start_light_next = item_reg.light_sample;
                        lamp_next        = LAMP_GREEN;
                        event_next       = EV_STARTED;
                    end
                end
                // a race that has just started cannot finish on the same tick
                if (timing_reg && light_done)
                begin
                    timing_next = 1'b0;
                    lamp_next   = LAMP_RED;
                    event_next  = EV_FINISHED;
                end
            end
        end
    end

    // time base
    assign time_ctrl.commit  = commit;
    assign time_ctrl.run     = timing_reg;
    assign time_ctrl.restart = start;

    rtc_time_base u_time_base (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (time_ctrl),
        .stat_next (time_next)
    );

    // result assembly
    always_comb
    begin
        result_next.race_running = timing_next;
        result_next.minutes      = time_next.digits.minutes;
        result_next.seconds      = time_next.digits.seconds;
        result_next.tenths       = time_next.digits.tenths;
        result_next.show_time    = timing_next
            && (time_next.tenth_count > TENTH_CNT_BITS'(display_delay_reg));
        result_next.lamp         = lamp_next;
        result_next.event_res    = event_next;
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= commit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            result_reg <= result_next;
        end
    end

    // race state moves with each committed tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_level_reg  <= 1'b0;
            stable_reg      <= '0;
            press_reg       <= 1'b0;
            long_seen_reg   <= 1'b0;
            hold_reg        <= '0;
            timing_reg      <= 1'b0;
            start_light_reg <= '0;
            lamp_reg        <= LAMP_OFF;
        end
        else if (commit)
        begin
            last_level_reg  <= item_reg.button_level;
            stable_reg      <= stable_next;
            press_reg       <= press_next;
            long_seen_reg   <= long_seen_next;
            hold_reg        <= hold_next;
            timing_reg      <= timing_next;
            start_light_reg <= start_light_next;
            lamp_reg        <= lamp_next;
        end
    end

    `RTC_ASSERT_NOW(a_start_runs, clk, rst_n,
        result_valid_reg && result_reg.event_res == EV_STARTED,
        result_reg.race_running && result_reg.lamp == LAMP_GREEN)
    `RTC_ASSERT_NOW(a_stop_red, clk, rst_n,
        result_valid_reg && (result_reg.event_res == EV_FINISHED
                             || result_reg.event_res == EV_ABORTED),
        !result_reg.race_running && result_reg.lamp == LAMP_RED)
    `RTC_ASSERT_NEXT(a_item_kept, clk, rst_n,
        item_valid_reg && !advance, item_valid_reg && $stable(item_reg))

endmodule

`default_nettype wire
